// File: src/assert_macros.svh
// Assertion macros used by the checker in psti_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define PSTI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay before the consequent.
`define PSTI_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// File: src/psti_pkg.sv
// Shared constants for the point versus moving segment impact-time block.
`default_nettype none

package psti_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int SCALE_BITS     = 30;
    localparam int TS_W           = 17;
    localparam int NZL_W          = 32;
    localparam int APB_DW         = 32;
    localparam int APB_AW         = 3;

    localparam logic [TS_W-1:0]  TS_RESET  = 17'd1092;
    localparam logic [NZL_W-1:0] NZL_RESET = 32'd4295;

    localparam logic REG_TS  = 1'b0;
    localparam logic REG_NZL = 1'b1;

    localparam int DIV_DEN_W_DEF = SCALE_BITS + 4;
    localparam int DIV_NUM_W_DEF = DIV_DEN_W_DEF + FRAC_BITS_DEF;

endpackage

`default_nettype wire

// File: src/psti_div.sv
// Pipelined restoring divider with quotient range check, one quotient bit per stage.
`default_nettype none

module psti_div
    import psti_pkg::*;
#(
    parameter int NW  = DIV_NUM_W_DEF,
    parameter int DNW = DIV_DEN_W_DEF,
    parameter int QW  = TS_W
) (
    input  wire logic           i_clk,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DNW-1:0] i_den,
    input  wire logic           i_ok,
    output logic      [QW-1:0]  o_quot,
    output logic                o_ok
);

    localparam int CW = (NW > DNW + QW) ? NW : DNW + QW;

    logic [NW-1:0]  r_rem  [0:QW];
    logic [DNW-1:0] r_den  [0:QW];
    logic [QW-1:0]  r_quot [0:QW];
    logic           r_ok   [0:QW];

    logic [NW-1:0]  n_rem  [0:QW-1];
    logic [QW-1:0]  n_quot [0:QW-1];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_num;
        r_den[0]  <= i_den;
        r_quot[0] <= '0;
        r_ok[0]   <= i_ok && (CW'(i_num) < (CW'(i_den) << QW));
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [CW-1:0] sh;
        logic          ge;

        always_comb begin
            sh        = CW'(r_den[g]) << (QW - 1 - g);
            ge        = CW'(r_rem[g]) >= sh;
            n_rem[g]  = ge ? NW'(CW'(r_rem[g]) - sh) : r_rem[g];
            n_quot[g] = ge ? (r_quot[g] | (QW'(1) << (QW - 1 - g))) : r_quot[g];
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= n_rem[g];
            r_den[g+1]  <= r_den[g];
            r_quot[g+1] <= n_quot[g];
            r_ok[g+1]   <= r_ok[g];
        end
    end

    assign o_quot = r_quot[QW];
    assign o_ok   = r_ok[QW];

endmodule

`default_nettype wire

// File: src/point_segment_time_of_impact.sv
// Earliest impact time of a moving point on a moving 2-D segment, signed Q16.16.
//
// Request channel: drive the twelve position and velocity ports and raise
// start; the request is taken at a rising edge with start high and busy low.
// busy is low whenever reset is released, so a request can enter every cycle.
// Result channel: o_done is high for exactly one cycle with o_hit and
// o_impact_time; the receiver cannot hold results off, and results leave in
// request order.
// The square root resolves one pair of bits per stage and the dividers one
// quotient bit per stage. Throughput: one request per cycle.
// Configuration: APB registers time_step at 0x0 and near_zero_limit at 0x4,
// written while no request is in flight.
// Reset: in-flight requests are dropped, registers return to 1092 and 4295.
// Outside a result cycle o_hit and o_impact_time read zero.
`default_nettype none

module point_segment_time_of_impact
    import psti_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] i_point_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_pos_y,
    input  wire logic signed [COORD_BITS-1:0] i_point_vel_x,
    input  wire logic signed [COORD_BITS-1:0] i_point_vel_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_a_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_a_pos_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_a_vel_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_a_vel_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_b_pos_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_b_pos_y,
    input  wire logic signed [COORD_BITS-1:0] i_end_b_vel_x,
    input  wire logic signed [COORD_BITS-1:0] i_end_b_vel_y,
    output logic                              o_done,
    output logic                              o_hit,
    output logic             [TS_W-1:0]       o_impact_time,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic        [APB_AW-1:0]     paddr,
    input  wire logic        [APB_DW-1:0]     pwdata,
    output logic             [APB_DW-1:0]     prdata,
    output logic                              pready
);

    localparam int DW      = COORD_BITS + 1;
    localparam int PW      = 2 * DW;
    localparam int AW      = 2 * DW + 2;
    localparam int KW      = $clog2(AW + 1);
    localparam int SW      = SCALE_BITS + 1;
    localparam int DXW     = 2 * SW + 2;
    localparam int SQS     = DXW / 2;
    localparam int RTW     = SQS;
    localparam int RMW     = RTW + 3;
    localparam int WW      = SW + 3;
    localparam int NW      = WW + FRAC_BITS;
    localparam int QW      = TS_W;
    localparam int DIVL    = QW + 1;
    localparam int PRW     = DW + QW + 1;
    localparam int EW      = DW + ((FRAC_BITS > QW) ? FRAC_BITS : QW) + 2;
    localparam int LATENCY = 12 + SQS + DIVL;

    typedef struct packed {
        logic signed [DW-1:0] dx0;
        logic signed [DW-1:0] dy0;
        logic signed [DW-1:0] dx1;
        logic signed [DW-1:0] dy1;
        logic signed [DW-1:0] dvx0;
        logic signed [DW-1:0] dvy0;
        logic signed [DW-1:0] dvx1;
        logic signed [DW-1:0] dvy1;
    } t_dif;

    typedef struct packed {
        logic signed [DW-1:0] dx0;
        logic signed [DW-1:0] dvx0;
        logic signed [DW-1:0] dx1;
        logic signed [DW-1:0] dvx1;
    } t_geo;

    typedef struct packed {
        logic                 vld;
        logic                 lin;
        logic                 lin_ok;
        logic                 dneg;
        logic signed [SW-1:0] sa;
        logic signed [SW-1:0] sb;
        logic signed [SW-1:0] sc;
        t_geo                 g;
        logic [DXW-1:0]       x;
        logic [RMW-1:0]       rem;
        logic [RTW-1:0]       root;
    } t_sq;

    typedef struct packed {
        logic vld;
        t_geo g;
    } t_dl;

    // configuration registers
    logic [TS_W-1:0]  r_ts;
    logic [NZL_W-1:0] r_nzl;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign busy   = !i_rst_n;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= TS_RESET;
            r_nzl <= NZL_RESET;
        end else if (cfg_wr) begin
            case (paddr[APB_AW-1])
                REG_TS:  r_ts  <= pwdata[TS_W-1:0];
                REG_NZL: r_nzl <= pwdata[NZL_W-1:0];
                default: r_ts  <= r_ts;
            endcase
        end
    end

    always_comb begin
        case (paddr[APB_AW-1])
            REG_TS:  prdata = APB_DW'(r_ts);
            REG_NZL: prdata = APB_DW'(r_nzl);
            default: prdata = '0;
        endcase
    end

    // stage valid bits
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_s9_vld;
    logic r_s10_vld, r_s11_vld, r_done;
    logic n_s1_vld;

    assign n_s1_vld = start && !busy;

    // stage 1: differences
    t_dif r_s1_d;

    always_ff @(posedge i_clk) begin
        r_s1_d.dx0  <= DW'(i_point_pos_x) - DW'(i_end_a_pos_x);
        r_s1_d.dy0  <= DW'(i_point_pos_y) - DW'(i_end_a_pos_y);
        r_s1_d.dx1  <= DW'(i_point_pos_x) - DW'(i_end_b_pos_x);
        r_s1_d.dy1  <= DW'(i_point_pos_y) - DW'(i_end_b_pos_y);
        r_s1_d.dvx0 <= DW'(i_point_vel_x) - DW'(i_end_a_vel_x);
        r_s1_d.dvy0 <= DW'(i_point_vel_y) - DW'(i_end_a_vel_y);
        r_s1_d.dvx1 <= DW'(i_point_vel_x) - DW'(i_end_b_vel_x);
        r_s1_d.dvy1 <= DW'(i_point_vel_y) - DW'(i_end_b_vel_y);
    end

    // stage 2: cross products
    logic signed [PW-1:0] r_s2_p [0:7];
    t_geo                 r_s2_g;

    always_ff @(posedge i_clk) begin
        r_s2_p[0]   <= r_s1_d.dvx0 * r_s1_d.dvy1;
        r_s2_p[1]   <= r_s1_d.dvy0 * r_s1_d.dvx1;
        r_s2_p[2]   <= r_s1_d.dx0 * r_s1_d.dvy1;
        r_s2_p[3]   <= r_s1_d.dvx0 * r_s1_d.dy1;
        r_s2_p[4]   <= r_s1_d.dy0 * r_s1_d.dvx1;
        r_s2_p[5]   <= r_s1_d.dvy0 * r_s1_d.dx1;
        r_s2_p[6]   <= r_s1_d.dx0 * r_s1_d.dy1;
        r_s2_p[7]   <= r_s1_d.dy0 * r_s1_d.dx1;
        r_s2_g.dx0  <= r_s1_d.dx0;
        r_s2_g.dvx0 <= r_s1_d.dvx0;
        r_s2_g.dx1  <= r_s1_d.dx1;
        r_s2_g.dvx1 <= r_s1_d.dvx1;
    end

    // stage 3: quadratic coefficients
    logic signed [AW-1:0] r_s3_a, r_s3_b, r_s3_c;
    t_geo                 r_s3_g;

    always_ff @(posedge i_clk) begin
        r_s3_a <= AW'(r_s2_p[0]) - AW'(r_s2_p[1]);
        r_s3_b <= (AW'(r_s2_p[2]) + AW'(r_s2_p[3])) - (AW'(r_s2_p[4]) + AW'(r_s2_p[5]));
        r_s3_c <= AW'(r_s2_p[6]) - AW'(r_s2_p[7]);
        r_s3_g <= r_s2_g;
    end

    // stage 4: magnitudes and thresholds
    logic [AW-1:0] n_s4_ma, n_s4_mb, n_s4_mc;
    logic          n_s4_lin;
    logic [AW-1:0] r_s4_ma, r_s4_mb, r_s4_mc, r_s4_m;
    logic          r_s4_sa, r_s4_sb, r_s4_sc, r_s4_lin, r_s4_linok;
    t_geo          r_s4_g;

    always_comb begin
        n_s4_ma  = AW'(r_s3_a[AW-1] ? -r_s3_a : r_s3_a);
        n_s4_mb  = AW'(r_s3_b[AW-1] ? -r_s3_b : r_s3_b);
        n_s4_mc  = AW'(r_s3_c[AW-1] ? -r_s3_c : r_s3_c);
        n_s4_lin = n_s4_ma < AW'(r_nzl);
    end

    always_ff @(posedge i_clk) begin
        r_s4_ma    <= n_s4_ma;
        r_s4_mb    <= n_s4_mb;
        r_s4_mc    <= n_s4_mc;
        r_s4_m     <= n_s4_mb | n_s4_mc | (n_s4_lin ? '0 : n_s4_ma);
        r_s4_sa    <= r_s3_a[AW-1];
        r_s4_sb    <= r_s3_b[AW-1];
        r_s4_sc    <= r_s3_c[AW-1];
        r_s4_lin   <= n_s4_lin;
        r_s4_linok <= n_s4_mb > AW'(r_nzl);
        r_s4_g     <= r_s3_g;
    end

    // stage 5: scale shift from the bit length
    logic [KW-1:0] n_s5_len, n_s5_k;
    logic [AW-1:0] r_s5_ma, r_s5_mb, r_s5_mc;
    logic          r_s5_sa, r_s5_sb, r_s5_sc, r_s5_lin, r_s5_linok;
    logic [KW-1:0] r_s5_k;
    t_geo          r_s5_g;

    always_comb begin
        n_s5_len = '0;
        for (int i = 0; i < AW; i++) begin
            if (r_s4_m[i]) begin
                n_s5_len = KW'(i + 1);
            end
        end
        n_s5_k = (n_s5_len > KW'(SCALE_BITS)) ? n_s5_len - KW'(SCALE_BITS) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_s5_ma    <= r_s4_ma;
        r_s5_mb    <= r_s4_mb;
        r_s5_mc    <= r_s4_mc;
        r_s5_sa    <= r_s4_sa;
        r_s5_sb    <= r_s4_sb;
        r_s5_sc    <= r_s4_sc;
        r_s5_lin   <= r_s4_lin;
        r_s5_linok <= r_s4_linok;
        r_s5_k     <= n_s5_k;
        r_s5_g     <= r_s4_g;
    end

    // stage 6: scaled coefficients
    logic [AW-1:0]        n_s6_xa, n_s6_xb, n_s6_xc;
    logic signed [SW-1:0] n_s6_va, n_s6_vb, n_s6_vc;
    logic signed [SW-1:0] r_s6_as, r_s6_bs, r_s6_cs;
    logic                 r_s6_lin, r_s6_linok;
    t_geo                 r_s6_g;

    always_comb begin
        n_s6_xa = r_s5_ma >> r_s5_k;
        n_s6_xb = r_s5_mb >> r_s5_k;
        n_s6_xc = r_s5_mc >> r_s5_k;
        n_s6_va = $signed({1'b0, n_s6_xa[SW-2:0]});
        n_s6_vb = $signed({1'b0, n_s6_xb[SW-2:0]});
        n_s6_vc = $signed({1'b0, n_s6_xc[SW-2:0]});
    end

    always_ff @(posedge i_clk) begin
        r_s6_as    <= r_s5_sa ? -n_s6_va : n_s6_va;
        r_s6_bs    <= r_s5_sb ? -n_s6_vb : n_s6_vb;
        r_s6_cs    <= r_s5_sc ? -n_s6_vc : n_s6_vc;
        r_s6_lin   <= r_s5_lin;
        r_s6_linok <= r_s5_linok;
        r_s6_g     <= r_s5_g;
    end

    // stage 7: discriminant products
    logic signed [2*SW-1:0] r_s7_bsq, r_s7_acs;
    logic signed [SW-1:0]   r_s7_as, r_s7_bs, r_s7_cs;
    logic                   r_s7_lin, r_s7_linok;
    t_geo                   r_s7_g;

    always_ff @(posedge i_clk) begin
        r_s7_bsq   <= r_s6_bs * r_s6_bs;
        r_s7_acs   <= r_s6_as * r_s6_cs;
        r_s7_as    <= r_s6_as;
        r_s7_bs    <= r_s6_bs;
        r_s7_cs    <= r_s6_cs;
        r_s7_lin   <= r_s6_lin;
        r_s7_linok <= r_s6_linok;
        r_s7_g     <= r_s6_g;
    end

    // discriminant, then square root two bits per stage
    t_sq                   r_sq [0:SQS];
    t_sq                   n_sq [0:SQS];
    logic signed [DXW-1:0] n_s8_d;

    always_comb begin
        n_s8_d          = DXW'(r_s7_bsq) - (DXW'(r_s7_acs) <<< 2);
        n_sq[0].vld     = r_s7_vld;
        n_sq[0].lin     = r_s7_lin;
        n_sq[0].lin_ok  = r_s7_linok;
        n_sq[0].dneg    = n_s8_d[DXW-1];
        n_sq[0].sa      = r_s7_as;
        n_sq[0].sb      = r_s7_bs;
        n_sq[0].sc      = r_s7_cs;
        n_sq[0].g       = r_s7_g;
        n_sq[0].x       = n_s8_d;
        n_sq[0].rem     = '0;
        n_sq[0].root    = '0;
    end

    for (genvar g = 0; g < SQS; g++) begin : g_sqrt
        logic [RMW-1:0] rin;
        logic [RMW-1:0] trial;

        always_comb begin
            rin          = {r_sq[g].rem[RMW-3:0], r_sq[g].x[DXW-1 -: 2]};
            trial        = RMW'({r_sq[g].root, 2'b01});
            n_sq[g+1]    = r_sq[g];
            n_sq[g+1].x  = r_sq[g].x << 2;
            if (rin >= trial) begin
                n_sq[g+1].rem  = rin - trial;
                n_sq[g+1].root = {r_sq[g].root[RTW-2:0], 1'b1};
            end else begin
                n_sq[g+1].rem  = rin;
                n_sq[g+1].root = {r_sq[g].root[RTW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j <= SQS; j++) begin
            if (!i_rst_n) begin
                r_sq[j] <= '0;
            end else begin
                r_sq[j] <= n_sq[j];
            end
        end
    end

    // stage 9: root numerators and divisors
    logic signed [WW-1:0] n_s9_s, n_s9_w, n_s9_num1, n_s9_den1, n_s9_num2;
    logic [WW-1:0]        n_s9_n1m, n_s9_d1m, n_s9_n2m, n_s9_d2m;
    logic                 n_s9_ok1, n_s9_ok2;
    logic [NW-1:0]        r_s9_n1, r_s9_n2;
    logic [WW-1:0]        r_s9_d1, r_s9_d2;
    logic                 r_s9_ok1, r_s9_ok2;
    t_geo                 r_s9_g;

    always_comb begin
        n_s9_s    = WW'($signed({1'b0, r_sq[SQS].root}));
        n_s9_w    = r_sq[SQS].sb[SW-1] ? (n_s9_s - WW'(r_sq[SQS].sb))
                                       : -(WW'(r_sq[SQS].sb) + n_s9_s);
        n_s9_num1 = r_sq[SQS].lin ? -WW'(r_sq[SQS].sc) : n_s9_w;
        n_s9_den1 = r_sq[SQS].lin ? WW'(r_sq[SQS].sb) : (WW'(r_sq[SQS].sa) <<< 1);
        n_s9_num2 = WW'(r_sq[SQS].sc) <<< 1;
        n_s9_n1m  = WW'(n_s9_num1[WW-1] ? -n_s9_num1 : n_s9_num1);
        n_s9_d1m  = WW'(n_s9_den1[WW-1] ? -n_s9_den1 : n_s9_den1);
        n_s9_n2m  = WW'(n_s9_num2[WW-1] ? -n_s9_num2 : n_s9_num2);
        n_s9_d2m  = WW'(n_s9_w[WW-1] ? -n_s9_w : n_s9_w);
        n_s9_ok1  = (r_sq[SQS].lin ? (r_sq[SQS].lin_ok && r_sq[SQS].sb != '0)
                                   : (!r_sq[SQS].dneg && r_sq[SQS].sa != '0))
                    && (n_s9_num1[WW-1] == n_s9_den1[WW-1]);
        n_s9_ok2  = !r_sq[SQS].lin && !r_sq[SQS].dneg && n_s9_w != '0
                    && (n_s9_num2[WW-1] == n_s9_w[WW-1]);
    end

    always_ff @(posedge i_clk) begin
        r_s9_n1  <= NW'(n_s9_n1m) << FRAC_BITS;
        r_s9_d1  <= n_s9_d1m;
        r_s9_ok1 <= n_s9_ok1;
        r_s9_n2  <= NW'(n_s9_n2m) << FRAC_BITS;
        r_s9_d2  <= n_s9_d2m;
        r_s9_ok2 <= n_s9_ok2;
        r_s9_g   <= r_sq[SQS].g;
    end

    // dividers with the geometry held alongside
    logic [QW-1:0] div1_quot, div2_quot;
    logic          div1_ok, div2_ok;
    t_dl           r_dl [0:DIVL-1];

    psti_div #(.NW(NW), .DNW(WW), .QW(QW)) u_div1 (
        .i_clk  (i_clk),
        .i_num  (r_s9_n1),
        .i_den  (r_s9_d1),
        .i_ok   (r_s9_ok1),
        .o_quot (div1_quot),
        .o_ok   (div1_ok)
    );

    psti_div #(.NW(NW), .DNW(WW), .QW(QW)) u_div2 (
        .i_clk  (i_clk),
        .i_num  (r_s9_n2),
        .i_den  (r_s9_d2),
        .i_ok   (r_s9_ok2),
        .o_quot (div2_quot),
        .o_ok   (div2_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl[0].vld <= 1'b0;
        end else begin
            r_dl[0].vld <= r_s9_vld;
        end
        r_dl[0].g <= r_s9_g;
        for (int j = 1; j < DIVL; j++) begin
            if (!i_rst_n) begin
                r_dl[j].vld <= 1'b0;
            end else begin
                r_dl[j].vld <= r_dl[j-1].vld;
            end
            r_dl[j].g <= r_dl[j-1].g;
        end
    end

    // stage 10: range check and position products
    logic signed [PRW-1:0] r_s10_m01, r_s10_m11, r_s10_m02, r_s10_m12;
    logic signed [DW-1:0]  r_s10_dx0, r_s10_dx1;
    logic [QW-1:0]         r_s10_t1, r_s10_t2;
    logic                  r_s10_ok1, r_s10_ok2;

    always_ff @(posedge i_clk) begin
        r_s10_m01 <= PRW'(r_dl[DIVL-1].g.dvx0) * $signed({1'b0, div1_quot});
        r_s10_m11 <= PRW'(r_dl[DIVL-1].g.dvx1) * $signed({1'b0, div1_quot});
        r_s10_m02 <= PRW'(r_dl[DIVL-1].g.dvx0) * $signed({1'b0, div2_quot});
        r_s10_m12 <= PRW'(r_dl[DIVL-1].g.dvx1) * $signed({1'b0, div2_quot});
        r_s10_dx0 <= r_dl[DIVL-1].g.dx0;
        r_s10_dx1 <= r_dl[DIVL-1].g.dx1;
        r_s10_t1  <= div1_quot;
        r_s10_t2  <= div2_quot;
        r_s10_ok1 <= div1_ok && div1_quot != '0 && div1_quot <= r_ts;
        r_s10_ok2 <= div2_ok && div2_quot != '0 && div2_quot <= r_ts;
    end

    // stage 11: strict betweenness on x
    logic signed [EW-1:0] n_s11_e01, n_s11_e11, n_s11_e02, n_s11_e12;
    logic                 n_s11_v1, n_s11_v2;
    logic                 r_s11_v1, r_s11_v2;
    logic [QW-1:0]        r_s11_t1, r_s11_t2;

    always_comb begin
        n_s11_e01 = (EW'(r_s10_dx0) <<< FRAC_BITS) + EW'(r_s10_m01);
        n_s11_e11 = (EW'(r_s10_dx1) <<< FRAC_BITS) + EW'(r_s10_m11);
        n_s11_e02 = (EW'(r_s10_dx0) <<< FRAC_BITS) + EW'(r_s10_m02);
        n_s11_e12 = (EW'(r_s10_dx1) <<< FRAC_BITS) + EW'(r_s10_m12);
        n_s11_v1  = r_s10_ok1 && n_s11_e01 != '0 && n_s11_e11 != '0
                    && (n_s11_e01[EW-1] != n_s11_e11[EW-1]);
        n_s11_v2  = r_s10_ok2 && n_s11_e02 != '0 && n_s11_e12 != '0
                    && (n_s11_e02[EW-1] != n_s11_e12[EW-1]);
    end

    always_ff @(posedge i_clk) begin
        r_s11_v1 <= n_s11_v1;
        r_s11_v2 <= n_s11_v2;
        r_s11_t1 <= r_s10_t1;
        r_s11_t2 <= r_s10_t2;
    end

    // stage 12: pick the earliest root
    logic          n_s12_hit;
    logic [QW-1:0] n_s12_time;
    logic          r_hit;
    logic [QW-1:0] r_time;

    always_comb begin
        n_s12_hit = r_s11_vld && (r_s11_v1 || r_s11_v2);
        if (!n_s12_hit) begin
            n_s12_time = '0;
        end else if (r_s11_v1 && r_s11_v2) begin
            n_s12_time = (r_s11_t1 < r_s11_t2) ? r_s11_t1 : r_s11_t2;
        end else if (r_s11_v1) begin
            n_s12_time = r_s11_t1;
        end else begin
            n_s12_time = r_s11_t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_s10_vld <= 1'b0;
            r_s11_vld <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_time    <= '0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= r_s6_vld;
            r_s9_vld  <= r_sq[SQS].vld;
            r_s10_vld <= r_dl[DIVL-1].vld;
            r_s11_vld <= r_s10_vld;
            r_done    <= r_s11_vld;
            r_hit     <= n_s12_hit;
            r_time    <= n_s12_time;
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_impact_time = r_time;

endmodule

`default_nettype wire

// File: src/psti_checker.sv
// Port-level checker for the impact-time block, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module psti_checker
    import psti_pkg::*;
#(
    parameter int LATENCY = 62
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic            o_done,
    input wire logic            o_hit,
    input wire logic [TS_W-1:0] o_impact_time
);

    `PSTI_ASSERT_DLY(a_latency, start && !busy, LATENCY, o_done, "request produced no result")
    `PSTI_ASSERT_IMP(a_source, o_done, $past(start && !busy, LATENCY), "result without request")
    `PSTI_ASSERT_IMP(a_quiet, !o_done, !o_hit && o_impact_time == '0, "result ports not quiet")
    `PSTI_ASSERT_IMP(a_time, o_done && o_hit, o_impact_time != '0, "hit with zero time")

endmodule

bind point_segment_time_of_impact psti_checker #(.LATENCY(LATENCY)) u_psti_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for point_segment_time_of_impact: random and directed requests.
`timescale 1ns / 100ps

module tb_top;
    import psti_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [31:0] point_pos_x;
        logic signed [31:0] point_pos_y;
        logic signed [31:0] point_vel_x;
        logic signed [31:0] point_vel_y;
        logic signed [31:0] end_a_pos_x;
        logic signed [31:0] end_a_pos_y;
        logic signed [31:0] end_a_vel_x;
        logic signed [31:0] end_a_vel_y;
        logic signed [31:0] end_b_pos_x;
        logic signed [31:0] end_b_pos_y;
        logic signed [31:0] end_b_vel_x;
        logic signed [31:0] end_b_vel_y;
    } t_motion_req;

    typedef struct packed {
        logic            hit;
        logic [TS_W-1:0] impact_time;
    } t_impact;

    localparam logic [APB_AW-1:0] TS_ADDR  = APB_AW'(4 * REG_TS);
    localparam logic [APB_AW-1:0] NZL_ADDR = APB_AW'(4 * REG_NZL);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] i_point_pos_x = '0, i_point_pos_y = '0;
    logic signed [31:0] i_point_vel_x = '0, i_point_vel_y = '0;
    logic signed [31:0] i_end_a_pos_x = '0, i_end_a_pos_y = '0;
    logic signed [31:0] i_end_a_vel_x = '0, i_end_a_vel_y = '0;
    logic signed [31:0] i_end_b_pos_x = '0, i_end_b_pos_y = '0;
    logic signed [31:0] i_end_b_vel_x = '0, i_end_b_vel_y = '0;
    logic o_done, o_hit;
    logic [TS_W-1:0] o_impact_time;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    logic [TS_W-1:0]  step_limit = TS_RESET;
    logic [NZL_W-1:0] zero_band = NZL_RESET;

    t_motion_req pending_reqs[$];
    t_impact     impact_q[$];
    t_motion_req cur_req;
    int          gap_pct = 21;
    int          mismatches = 0;

    point_segment_time_of_impact dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_point_pos_x(i_point_pos_x), .i_point_pos_y(i_point_pos_y),
        .i_point_vel_x(i_point_vel_x), .i_point_vel_y(i_point_vel_y),
        .i_end_a_pos_x(i_end_a_pos_x), .i_end_a_pos_y(i_end_a_pos_y),
        .i_end_a_vel_x(i_end_a_vel_x), .i_end_a_vel_y(i_end_a_vel_y),
        .i_end_b_pos_x(i_end_b_pos_x), .i_end_b_pos_y(i_end_b_pos_y),
        .i_end_b_vel_x(i_end_b_vel_x), .i_end_b_vel_y(i_end_b_vel_y),
        .o_done(o_done), .o_hit(o_hit), .o_impact_time(o_impact_time),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic void queue_req(t_motion_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic longint scale_down(t_wide v, int k);
        t_wide mag;
        mag = (v < 0) ? -v : v;
        mag = mag >> k;
        return (v < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > x) bits = bits >> 2;
        while (bits != 0) begin
            if (x >= res + bits) begin
                x = x - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    function automatic bit between_ends(longint co[12], longint t);
        t_wide px, ux, vx;
        if (t <= 0 || t > longint'(step_limit)) return 1'b0;
        px = t_wide'(co[0]) * 65536 + t_wide'(co[2]) * t_wide'(t);
        ux = t_wide'(co[4]) * 65536 + t_wide'(co[6]) * t_wide'(t);
        vx = t_wide'(co[8]) * 65536 + t_wide'(co[10]) * t_wide'(t);
        return (ux < px && px < vx) || (vx < px && px < ux);
    endfunction

    function automatic t_impact predict_impact(t_motion_req r);
        longint co[12];
        longint dx0, dy0, dx1, dy1, dvx0, dvy0, dvx1, dvy1;
        t_wide qa, qb, qc, mag_a, mag_b, mag_c, mask;
        int len, k;
        longint sa, sb, sc, disc, root, w, t1, t2, best;
        bit hit, v1, v2;
        t_impact res;
        co = '{r.point_pos_x, r.point_pos_y, r.point_vel_x, r.point_vel_y,
               r.end_a_pos_x, r.end_a_pos_y, r.end_a_vel_x, r.end_a_vel_y,
               r.end_b_pos_x, r.end_b_pos_y, r.end_b_vel_x, r.end_b_vel_y};
        dx0 = co[0] - co[4];   dy0 = co[1] - co[5];
        dx1 = co[0] - co[8];   dy1 = co[1] - co[9];
        dvx0 = co[2] - co[6];  dvy0 = co[3] - co[7];
        dvx1 = co[2] - co[10]; dvy1 = co[3] - co[11];
        qa = t_wide'(dvx0) * t_wide'(dvy1) - t_wide'(dvy0) * t_wide'(dvx1);
        qb = t_wide'(dx0) * t_wide'(dvy1) + t_wide'(dvx0) * t_wide'(dy1)
           - t_wide'(dy0) * t_wide'(dvx1) - t_wide'(dvy0) * t_wide'(dx1);
        qc = t_wide'(dx0) * t_wide'(dy1) - t_wide'(dy0) * t_wide'(dx1);
        mag_a = (qa < 0) ? -qa : qa;
        mag_b = (qb < 0) ? -qb : qb;
        mag_c = (qc < 0) ? -qc : qc;
        hit = 1'b0;
        best = 0;
        len = 0;
        if (mag_a < t_wide'({96'd0, zero_band})) begin
            if (mag_b > t_wide'({96'd0, zero_band})) begin
                mask = mag_b | mag_c;
                for (int i = 0; i < 128; i++) if (mask[i]) len = i + 1;
                k = (len > SCALE_BITS) ? len - SCALE_BITS : 0;
                sb = scale_down(qb, k);
                sc = scale_down(qc, k);
                if (sb != 0) begin
                    t1 = (-sc * 65536) / sb;
                    if (between_ends(co, t1)) begin
                        hit = 1'b1;
                        best = t1;
                    end
                end
            end
        end else begin
            mask = mag_a | mag_b | mag_c;
            for (int i = 0; i < 128; i++) if (mask[i]) len = i + 1;
            k = (len > SCALE_BITS) ? len - SCALE_BITS : 0;
            sa = scale_down(qa, k);
            sb = scale_down(qb, k);
            sc = scale_down(qc, k);
            disc = sb * sb - 4 * sa * sc;
            if (disc >= 0) begin
                root = longint'(floor_sqrt(disc));
                w = (sb >= 0) ? -(sb + root) : root - sb;
                v1 = 1'b0;
                v2 = 1'b0;
                t1 = 0;
                t2 = 0;
                if (sa != 0) begin
                    t1 = (w * 65536) / (2 * sa);
                    v1 = between_ends(co, t1);
                end
                if (w != 0) begin
                    t2 = (2 * sc * 65536) / w;
                    v2 = between_ends(co, t2);
                end
                if (v1 && v2) begin
                    hit = 1'b1;
                    best = (t1 < t2) ? t1 : t2;
                end else if (v1) begin
                    hit = 1'b1;
                    best = t1;
                end else if (v2) begin
                    hit = 1'b1;
                    best = t2;
                end
            end
        end
        res.hit = hit;
        res.impact_time = hit ? best[TS_W-1:0] : '0;
        return res;
    endfunction

    // Segment at height h above the point, swept down onto it at time tc.
    function automatic t_motion_req sweep_req(longint px, longint py, longint pvx,
                                              longint h, longint tc, longint half,
                                              longint spread);
        t_motion_req r;
        longint vy;
        vy = (tc == 0) ? 0 : -(h * 65536) / tc;
        r.point_pos_x = 32'(px);          r.point_pos_y = 32'(py);
        r.point_vel_x = 32'(pvx);         r.point_vel_y = '0;
        r.end_a_pos_x = 32'(px - half);   r.end_a_pos_y = 32'(py + h);
        r.end_a_vel_x = 32'(pvx - spread); r.end_a_vel_y = 32'(vy);
        r.end_b_pos_x = 32'(px + half);   r.end_b_pos_y = 32'(py + h);
        r.end_b_vel_x = 32'(pvx + spread); r.end_b_vel_y = 32'(vy);
        return r;
    endfunction

    function automatic t_motion_req noise_req(int span);
        t_motion_req r;
        logic [383:0] bits;
        for (int i = 0; i < 12; i++) begin
            bits[i*32 +: 32] = (span >= 32) ? $urandom()
                             : 32'($signed($urandom_range(2 ** span)) - 2 ** (span - 1));
        end
        r = bits;
        return r;
    endfunction

    function automatic t_motion_req random_req();
        int pick;
        longint ts;
        t_motion_req r;
        pick = $urandom_range(99);
        ts = (step_limit == 0) ? 1 : longint'(step_limit);
        if (pick < 55) begin
            r = sweep_req($signed($urandom_range(1 << 20)) - (1 << 19),
                          $signed($urandom_range(1 << 20)) - (1 << 19),
                          $signed($urandom_range(1 << 19)) - (1 << 18),
                          $signed($urandom_range(1 << 18)) - (1 << 17),
                          $urandom_range(32'(ts + ts / 4), 1),
                          $urandom_range(1 << 18),
                          $signed($urandom_range(1 << 18)) - (1 << 17));
        end else if (pick < 70) begin
            // equal end velocities keep the quadratic term at zero
            r = noise_req(20);
            r.end_b_vel_x = r.end_a_vel_x;
            r.end_b_vel_y = r.end_a_vel_y;
        end else if (pick < 85) begin
            r = noise_req($urandom_range(24, 8));
        end else begin
            r = noise_req(32);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) impact_q.insert(impact_q.size(), predict_impact(cur_req));
            if (start && busy) begin
            end else if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
                cur_req = pending_reqs.pop_front();
                start <= 1'b1;
                i_point_pos_x <= cur_req.point_pos_x;
                i_point_pos_y <= cur_req.point_pos_y;
                i_point_vel_x <= cur_req.point_vel_x;
                i_point_vel_y <= cur_req.point_vel_y;
                i_end_a_pos_x <= cur_req.end_a_pos_x;
                i_end_a_pos_y <= cur_req.end_a_pos_y;
                i_end_a_vel_x <= cur_req.end_a_vel_x;
                i_end_a_vel_y <= cur_req.end_a_vel_y;
                i_end_b_pos_x <= cur_req.end_b_pos_x;
                i_end_b_pos_y <= cur_req.end_b_pos_y;
                i_end_b_vel_x <= cur_req.end_b_vel_x;
                i_end_b_vel_y <= cur_req.end_b_vel_y;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_impact want;
        if (i_rst_n && o_done) begin
            if (impact_q.size() == 0) begin
                $display("%0t: unexpected result hit=%0d time=%0d", $realtime, o_hit,
                         o_impact_time);
                mismatches++;
            end else begin
                want = impact_q.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $realtime, want.hit, o_hit);
                    mismatches++;
                end
                if (o_impact_time !== want.impact_time) begin
                    $display("%0t: impact_time expected %0d actual %0d", $realtime,
                             want.impact_time, o_impact_time);
                    mismatches++;
                end
            end
        end
    end

    task automatic reg_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == TS_ADDR) step_limit = data[TS_W-1:0];
        else zero_band = data;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || start || impact_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [APB_DW-1:0] ts, logic [APB_DW-1:0] nzl, int count);
        reg_write(TS_ADDR, ts);
        reg_write(NZL_ADDR, nzl);
        repeat (count) queue_req(random_req());
        drain();
    endtask

    initial begin
        t_motion_req r;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_req('0);
        queue_req({12{32'h7FFF_FFFF}});
        queue_req({12{32'h8000_0000}});
        queue_req({12{32'hFFFF_FFFF}});
        queue_req({6{32'h7FFF_FFFF, 32'h8000_0000}});
        queue_req(sweep_req(0, 0, 0, 65536, 546, 65536, 0));
        queue_req(sweep_req(0, 0, 0, 65536, 1092, 65536, 0));
        queue_req(sweep_req(0, 0, 0, 65536, 1093, 65536, 0));
        queue_req(sweep_req(0, 0, 0, 65536, 1, 65536, 0));
        queue_req(sweep_req(0, 0, 0, -65536, 300, 4096, 0));
        queue_req(sweep_req(0, 0, 0, 0, 0, 65536, 0));
        queue_req(sweep_req(0, 0, 0, 65536, 500, 0, 0));
        queue_req(sweep_req(1 << 20, -(1 << 18), 3 << 16, 70000, 700,
                            20000, 1 << 18));
        queue_req(sweep_req(0, 0, 0, 65536, 800, 1, 1 << 20));
        // segment rotating about its midpoint: both quadratic roots in play
        r = '0;
        r.point_pos_x = 32'sd1000;
        r.end_a_pos_x = -32'sd65536; r.end_a_pos_y = 32'sd65536;
        r.end_a_vel_y = -32'sd65536 * 60;
        r.end_b_pos_x = 32'sd65536;  r.end_b_pos_y = -32'sd65536;
        r.end_b_vel_y = 32'sd65536 * 60;
        queue_req(r);
        r.point_vel_y = 32'sd3 << 16;
        queue_req(r);
        r = sweep_req(0, 0, 0, 65536, 600, 65536, 0);
        r.end_a_vel_x = 32'sd1;
        queue_req(r);
        r = sweep_req(0, 0, 1 << 16, 65536, 600, 65536, 0);
        r.end_b_pos_x = r.end_a_pos_x;
        queue_req(r);
        drain();

        gap_pct = 21;
        run_phase(32'd65536, 32'd0, 300);
        run_phase(32'hFFFE_0000, 32'hFFFF_FFFF, 30);
        gap_pct = 76;
        run_phase($urandom(), $urandom_range(1 << 20), 300);
        run_phase(32'd16, 32'd4295, 30);
        gap_pct = 0;
        run_phase(32'd1092, $urandom(), 300);
        run_phase(32'h0001_FFFF, 32'd1, 40);

        repeat (80) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("point_segment_time_of_impact verification clean");
        end else begin
            $display("point_segment_time_of_impact verification failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("point_segment_time_of_impact verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/psti_pkg.sv
src/psti_div.sv
src/point_segment_time_of_impact.sv
src/psti_checker.sv
tb/tb_top.sv
